// ===== design/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg: shared types and constants of the run-length byte encoder
// Encoder modes, emit byte selection, and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

	// default maximum literal segment length
	localparam int LITERAL_MAX_DEF = 128;
	// longest run, and bias added to a run length to form its header byte
	localparam int RUN_MAX      = 129;
	localparam int RUN_HDR_BIAS = 126;

	// encoder mode: nothing held, one byte held, run open
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_HELD = 2'd1,
		MODE_RUN  = 2'd2
	} mode_t;

	// source of the byte handed to the word packer
	typedef enum logic [1:0] {
		EMIT_RUN_HDR = 2'd0,
		EMIT_RUN_VAL = 2'd1,
		EMIT_LIT_HDR = 2'd2,
		EMIT_LIT_BODY = 2'd3
	} emit_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      load_in;   // latch the accepted source byte and last flag
		logic      set_held;  // held byte <= latched source byte
		logic      run_start; // open run of two with the source byte
		logic      run_inc;   // extend the open run
		logic      run_clr;   // clear the run length
		logic      mode_we;
		mode_t     mode_d;
		logic      lit_add;   // append held byte to the literal store
		logic      lit_clr;   // literal segment written out
		logic      idx_clr;   // restart literal read index at zero
		logic      idx_inc;   // advance literal read index
		emit_sel_t emit_sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  last;          // latched chunk_last
		logic  held_eq;       // source byte equals held byte
		logic  run_ext;       // source byte extends the open run
		logic  lit_empty;
		logic  lit_full_next; // one more literal fills the store
		logic  body_last;     // read index at the final literal
	} dp_stat_t;

endpackage : rbe_pkg

`default_nettype wire

// ===== design/rbe_packer.sv =====
// ----------------------------------------------------------------------------
// rbe_packer: byte to word packer
// Collects encoded bytes four to a 32-bit word, first byte low, and holds
// the finished word in an output register. A final byte closes a partial word.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_packer
	import rbe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte side
	input  wire logic        byte_valid,
	input  wire logic [7:0]  byte_data,
	input  wire logic        byte_final,
	output logic             byte_ready,
	// word side
	output logic             word_valid,
	input  wire logic        word_ready,
	output logic [31:0]      word_data,
	output logic [2:0]       word_count,
	output logic             word_end
);

	logic [23:0] pack_q;
	logic [1:0]  fill_q;
	logic [31:0] word_q;
	logic [2:0]  count_q;
	logic        end_q;
	logic        valid_q;
	logic        closes;
	logic        push;
	logic [31:0] merged;

	// a byte that completes a word needs the output register free
	assign closes     = (fill_q == 2'd3) || byte_final;
	assign byte_ready = !closes || !valid_q || word_ready;
	assign push       = byte_valid && byte_ready;
	assign merged     = {8'h00, pack_q} | (32'(byte_data) << {fill_q, 3'b000});

	// collect bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			if (closes) begin
				pack_q <= '0;
				fill_q <= '0;
			end else begin
				pack_q <= merged[23:0];
				fill_q <= fill_q + 2'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			word_q  <= '0;
			count_q <= '0;
			end_q   <= 1'b0;
		end else if (push && closes) begin
			valid_q <= 1'b1;
			word_q  <= merged;
			count_q <= {1'b0, fill_q} + 3'd1;
			end_q   <= byte_final;
		end else if (word_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign word_valid = valid_q;
	assign word_data  = word_q;
	assign word_count = count_q;
	assign word_end   = end_q;

endmodule : rbe_packer

`default_nettype wire

// ===== design/rbe_datapath.sv =====
// ----------------------------------------------------------------------------
// rbe_datapath: encoder datapath
// Source byte latch, held byte, open run, literal store with its count and
// read index, and the mux that selects the next encoded byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_datapath
	import rbe_pkg::*;
#(
	parameter int LITERAL_MAX = LITERAL_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	output logic [7:0]      emit_byte
);

	localparam int AW = $clog2(LITERAL_MAX);
	localparam int CW = $clog2(LITERAL_MAX + 1);

	logic [7:0]    in_byte_q;
	logic          last_q;
	logic [7:0]    held_q;
	logic [7:0]    run_val_q;
	logic [7:0]    run_len_q;
	mode_t         mode_q;
	logic [CW-1:0] lit_cnt_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_q;
	logic [7:0]    lit_mem [LITERAL_MAX];

	// source latch, held byte, run and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_byte_q <= '0;
			last_q    <= 1'b0;
			held_q    <= '0;
			run_val_q <= '0;
			run_len_q <= '0;
			mode_q    <= MODE_IDLE;
		end else begin
			if (cmd.load_in) begin
				in_byte_q <= in_byte;
				last_q    <= in_last;
			end
			if (cmd.set_held)
				held_q <= in_byte_q;
			if (cmd.run_start) begin
				run_val_q <= in_byte_q;
				run_len_q <= 8'd2;
			end else if (cmd.run_inc) begin
				run_len_q <= run_len_q + 8'd1;
			end else if (cmd.run_clr) begin
				run_len_q <= '0;
			end
			if (cmd.mode_we)
				mode_q <= cmd.mode_d;
		end
	end

	// literal count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.lit_add)
				lit_cnt_q <= lit_cnt_q + CW'(1);
			else if (cmd.lit_clr)
				lit_cnt_q <= '0;
			idx_q <= rd_addr;
		end
	end

	// read address: restart, advance or hold so the read data stays put
	always_comb begin
		if (cmd.idx_clr)
			rd_addr = '0;
		else if (cmd.idx_inc)
			rd_addr = idx_q + AW'(1);
		else
			rd_addr = idx_q;
	end

	// literal store, registered read
	always_ff @(posedge clk) begin
		if (cmd.lit_add)
			lit_mem[lit_cnt_q[AW-1:0]] <= held_q;
		rd_data_q <= lit_mem[rd_addr];
	end

	// status
	assign stat.mode          = mode_q;
	assign stat.last          = last_q;
	assign stat.held_eq       = (in_byte_q == held_q);
	assign stat.run_ext       = (in_byte_q == run_val_q) && (run_len_q < 8'(RUN_MAX));
	assign stat.lit_empty     = (lit_cnt_q == '0);
	assign stat.lit_full_next = (lit_cnt_q == CW'(LITERAL_MAX - 1));
	assign stat.body_last     = (CW'(idx_q) == lit_cnt_q - CW'(1));

	// encoded byte select
	always_comb begin
		unique case (cmd.emit_sel)
			EMIT_RUN_HDR:  emit_byte = run_len_q + 8'(RUN_HDR_BIAS);
			EMIT_RUN_VAL:  emit_byte = run_val_q;
			EMIT_LIT_HDR:  emit_byte = 8'(lit_cnt_q - CW'(1));
			EMIT_LIT_BODY: emit_byte = rd_data_q;
			default:       emit_byte = rd_data_q;
		endcase
	end

endmodule : rbe_datapath

`default_nettype wire

// ===== design/rbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbe_ctrl: encoder controller
// Accepts one source byte, decides run/literal handling, and sequences the
// header, value and literal bytes into the packer, then the chunk-end flush.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_ctrl
	import rbe_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	input  wire logic     byte_ready,
	output logic          byte_valid,
	output logic          byte_final
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_EVAL     = 7'b0000010,
		ST_TAIL     = 7'b0000100,
		ST_RUN_HDR  = 7'b0001000,
		ST_RUN_VAL  = 7'b0010000,
		ST_LIT_HDR  = 7'b0100000,
		ST_LIT_BODY = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   final_q;
	logic   final_d;
	state_t after;

	// where to go once the byte's own work is done
	assign after = stat.last ? ST_TAIL : ST_IDLE;

	always_comb begin
		state_d    = state_q;
		final_d    = final_q;
		cmd        = '0;
		cmd.mode_d = MODE_IDLE;
		cmd.emit_sel = EMIT_RUN_HDR;
		in_ready   = 1'b0;
		byte_valid = 1'b0;
		byte_final = 1'b0;
		unique case (state_q)
			// wait for a source byte
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid)
					state_d = ST_EVAL;
			end
			// run or literal decision for the new byte
			ST_EVAL: begin
				unique case (stat.mode)
					MODE_HELD: begin
						if (stat.held_eq) begin
							cmd.run_start = 1'b1;
							cmd.mode_we   = 1'b1;
							cmd.mode_d    = MODE_RUN;
							state_d = stat.lit_empty ? after : ST_LIT_HDR;
						end else begin
							cmd.lit_add  = 1'b1;
							cmd.set_held = 1'b1;
							state_d = stat.lit_full_next ? ST_LIT_HDR : after;
						end
					end
					MODE_RUN: begin
						if (stat.run_ext) begin
							cmd.run_inc = 1'b1;
							state_d = after;
						end else begin
							cmd.set_held = 1'b1;
							cmd.mode_we  = 1'b1;
							cmd.mode_d   = MODE_HELD;
							state_d = ST_RUN_HDR;
						end
					end
					default: begin
						cmd.set_held = 1'b1;
						cmd.mode_we  = 1'b1;
						cmd.mode_d   = MODE_HELD;
						state_d = after;
					end
				endcase
			end
			// chunk end: close the run, or add the held byte and close literals
			ST_TAIL: begin
				cmd.run_clr = (stat.mode != MODE_RUN);
				cmd.mode_we = (stat.mode != MODE_RUN);
				cmd.mode_d  = MODE_IDLE;
				if (stat.mode == MODE_RUN) begin
					final_d = 1'b1;
					state_d = ST_RUN_HDR;
				end else if (stat.mode == MODE_HELD) begin
					cmd.lit_add = 1'b1;
					final_d = 1'b1;
					state_d = ST_LIT_HDR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			// run header byte
			ST_RUN_HDR: begin
				cmd.emit_sel = EMIT_RUN_HDR;
				byte_valid   = 1'b1;
				if (byte_ready)
					state_d = ST_RUN_VAL;
			end
			// run value byte
			ST_RUN_VAL: begin
				cmd.emit_sel = EMIT_RUN_VAL;
				byte_valid   = 1'b1;
				byte_final   = final_q;
				if (byte_ready) begin
					if (final_q) begin
						cmd.run_clr = 1'b1;
						cmd.mode_we = 1'b1;
						cmd.mode_d  = MODE_IDLE;
						final_d = 1'b0;
						state_d = ST_IDLE;
					end else begin
						state_d = after;
					end
				end
			end
			// literal header; first store read goes out here
			ST_LIT_HDR: begin
				cmd.emit_sel = EMIT_LIT_HDR;
				cmd.idx_clr  = 1'b1;
				byte_valid   = 1'b1;
				if (byte_ready)
					state_d = ST_LIT_BODY;
			end
			// literal bytes, one per transfer
			ST_LIT_BODY: begin
				cmd.emit_sel = EMIT_LIT_BODY;
				byte_valid   = 1'b1;
				byte_final   = final_q && stat.body_last;
				if (byte_ready) begin
					if (stat.body_last) begin
						cmd.lit_clr = 1'b1;
						if (final_q) begin
							final_d = 1'b0;
							state_d = ST_IDLE;
						end else begin
							state_d = after;
						end
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				final_d = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

endmodule : rbe_ctrl

`default_nettype wire

// ===== design/rle_byte_encoder.sv =====
// Sequence: each source byte is accepted in ST_IDLE and decided in ST_EVAL; each
//   encoded byte is one transfer into the packer, a chunk end adds ST_TAIL, and a
//   literal segment emits up to LITERAL_MAX + 1 bytes (header and body).
// Flow: a new source byte is taken only after the last one's encoded bytes are out,
//   and byte transfers stall on m_tready when the output register is still full.
// Reset: arst_n clears all control state; the literal store is not cleared.
// ----------------------------------------------------------------------------
// rle_byte_encoder: run-length byte encoder, top level
// Greedy run-length encoding (literal header count - 1, run header length + 126) of a byte chunk into 32-bit words,
// four encoded bytes per word, partial word flushed at chunk end.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_byte_encoder
	import rbe_pkg::*;
#(
	parameter int LITERAL_MAX = LITERAL_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// source bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tlast,  // chunk_last
	// encoded words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // [31:0] out_word, [34:32] byte_count, zero fill
	output logic             m_tlast   // chunk_end
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [7:0] emit_byte;
	logic       byte_valid;
	logic       byte_ready;
	logic       byte_final;
	logic [31:0] word_data;
	logic [2:0]  word_count;

	rbe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.stat       (stat),
		.cmd        (cmd),
		.byte_ready (byte_ready),
		.byte_valid (byte_valid),
		.byte_final (byte_final)
	);

	rbe_datapath #(
		.LITERAL_MAX (LITERAL_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.emit_byte (emit_byte)
	);

	rbe_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (emit_byte),
		.byte_final (byte_final),
		.byte_ready (byte_ready),
		.word_valid (m_tvalid),
		.word_ready (m_tready),
		.word_data  (word_data),
		.word_count (word_count),
		.word_end   (m_tlast)
	);

	assign m_tdata = {5'b00000, word_count, word_data};

endmodule : rle_byte_encoder

`default_nettype wire
